// ===== src/scsi_controller_register_file_top_macros.svh =====
// Assertion macros shared by the SCSI register file RTL.
`ifndef SCSI_CONTROLLER_REGISTER_FILE_TOP_MACROS_SVH
`define SCSI_CONTROLLER_REGISTER_FILE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCSIRF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCSIRF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/scsirf_pkg.sv =====
// Shared types, register offsets, bit masks and helper functions of the SCSI register file.
package scsirf_pkg;

   // Field widths of the bus access and of the result.
   localparam int OFFSET_W = 12;
   localparam int SIZE_W   = 4;
   localparam int DATA_W   = 32;
   localparam int BYTE_W   = 8;

   // Default depth of the register file in bytes.
   localparam int REG_FILE_BYTES_DEF = 256;

   // Access kinds and sizes.
   localparam logic              OP_READ   = 1'b0;
   localparam logic              OP_WRITE  = 1'b1;
   localparam logic [SIZE_W-1:0] SIZE_BYTE = 4'd1;
   localparam logic [SIZE_W-1:0] SIZE_WORD = 4'd4;

   // Register offsets inside the window.
   localparam logic [OFFSET_W-1:0] OFF_DSTAT  = 12'h00C;
   localparam logic [OFFSET_W-1:0] OFF_ISTAT  = 12'h014;
   localparam logic [OFFSET_W-1:0] OFF_CTEST2 = 12'h01A;
   localparam logic [OFFSET_W-1:0] OFF_CTEST3 = 12'h01B;
   localparam logic [OFFSET_W-1:0] OFF_SIST0  = 12'h042;
   localparam logic [OFFSET_W-1:0] OFF_SIST1  = 12'h043;
   localparam logic [OFFSET_W-1:0] OFF_STEST1 = 12'h04D;
   localparam logic [OFFSET_W-1:0] OFF_STEST3 = 12'h04F;
   localparam logic [OFFSET_W-1:0] OFF_STEST4 = 12'h052;

   // Reset values of the registers that do not reset to zero.
   localparam logic [BYTE_W-1:0] DSTAT_RESET  = 8'h80;
   localparam logic [BYTE_W-1:0] CTEST3_RESET = 8'hA0;
   localparam logic [BYTE_W-1:0] STEST4_RESET = 8'hC0;

   // Flag bits touched by side effects.
   localparam logic [BYTE_W-1:0] DSTAT_SIR   = 8'h04;
   localparam logic [BYTE_W-1:0] ISTAT_DIP   = 8'h01;
   localparam logic [BYTE_W-1:0] ISTAT_SIP   = 8'h02;
   localparam logic [BYTE_W-1:0] ISTAT_SIGP  = 8'h20;
   localparam logic [BYTE_W-1:0] SIST0_MA    = 8'h80;
   localparam logic [BYTE_W-1:0] SIST1_STO   = 8'h04;
   localparam logic [BYTE_W-1:0] STEST1_QEN  = 8'h08;
   localparam logic [BYTE_W-1:0] STEST3_CSF  = 8'h02;
   localparam logic [BYTE_W-1:0] STEST4_LOCK = 8'h20;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;    // latch the accepted item and read the array
      logic       execute;    // carry out the item and load the result
      logic       wide_step;  // write one more byte of a four-byte write
      logic [1:0] byte_sel;   // byte lane of the current array write
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic wide_write;       // the held item is an accepted four-byte write
   } sts_type;

   // Start offsets of the 32-bit registers that take four-byte writes.
   function automatic logic is_wide_reg(input logic [OFFSET_W-1:0] off);
      logic hit;
      hit = 1'b0;
      case (off)
         12'h010, 12'h01C, 12'h02C, 12'h034, 12'h05C, 12'h060, 12'h064,
         12'h068, 12'h06C, 12'h070, 12'h074, 12'h078, 12'h07C: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Value an array entry holds after reset.
   function automatic logic [BYTE_W-1:0] reg_reset_value(input logic [OFFSET_W-1:0] off);
      logic [BYTE_W-1:0] val;
      val = '0;
      case (off)
         OFF_DSTAT:  val = DSTAT_RESET;
         OFF_CTEST3: val = CTEST3_RESET;
         OFF_STEST4: val = STEST4_RESET;
         default:    val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== src/scsirf_req_if.sv =====
// Request channel interface: one bus access per item.
interface scsirf_req_if import scsirf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [OFFSET_W-1:0] reg_offset;
   logic [SIZE_W-1:0]   access_size;
   logic [DATA_W-1:0]   write_data;

   modport source (output valid, output operation, output reg_offset,
                   output access_size, output write_data, input ready);
   modport sink   (input valid, input operation, input reg_offset,
                   input access_size, input write_data, output ready);
endinterface

// ===== src/scsirf_rsp_if.sv =====
// Response channel interface: one result per item.
interface scsirf_rsp_if import scsirf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_data;
   logic              status;

   modport source (output valid, output read_data, output status, input ready);
   modport sink   (input valid, input read_data, input status, output ready);
endinterface

// ===== src/scsi_controller_register_file_top.sv =====
// Top level of the SCSI controller register file.
//
// The block serves bus accesses to a byte-wide register window. Each item on
// the req_chan channel is one read or write; each produces exactly one item on
// the rsp_chan channel with the byte read (zero for writes and rejected
// accesses) and a reject flag. Channels use valid/ready; an item moves on a
// rising edge where both are high.
// The result is loaded into the result register when the item executes,
// provided the result register is free.
// Only one item is in the block at a time: a new item is accepted only once the
// previous one is through. Four-byte writes also pass through the WIDE state,
// since the register array has a single write port and takes one byte per cycle.
// Reset clears the valid bits of the whole array at once, so unwritten
// entries read their reset values; no clearing pass is needed.
// When the receiver stalls, the result register holds its item and the next
// access is accepted but waits before it executes, so no result is lost.
`include "scsi_controller_register_file_top_macros.svh"

module scsi_controller_register_file_top import scsirf_pkg::*; #(
   parameter int REG_FILE_BYTES = REG_FILE_BYTES_DEF
) (
   input logic          clock,
   input logic          reset,
   scsirf_req_if.sink   req_chan,
   scsirf_rsp_if.source rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   // Sequencing of each access.
   scsirf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Register storage and access decode.
   scsirf_dp #(
      .REG_FILE_BYTES (REG_FILE_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_chan.operation),
      .req_reg_offset  (req_chan.reg_offset),
      .req_access_size (req_chan.access_size),
      .req_write_data  (req_chan.write_data),
      .rsp_read_data   (rsp_chan.read_data),
      .rsp_status      (rsp_chan.status)
   );

   // Only one item is in the block at a time.
   `SCSIRF_ASSERT_NXT(a_busy_after_accept, clock, reset,
                      req_chan.valid && req_chan.ready, !req_chan.ready,
                      "item accepted while another is in progress")
   // Executing an item always leaves a result waiting.
   `SCSIRF_ASSERT_NXT(a_result_after_execute, clock, reset,
                      cmd.execute, rsp_chan.valid,
                      "executed item produced no result")
   // A result appears only from an executed item.
   `SCSIRF_ASSERT_IMP(a_result_from_execute, clock, reset,
                      $rose(rsp_chan.valid), $past(cmd.execute),
                      "result appeared without an executed item")
   // The array write lanes of a four-byte write never overlap a new item.
   `SCSIRF_ASSERT_IMP(a_no_accept_in_wide, clock, reset,
                      cmd.wide_step, !req_chan.ready,
                      "item accepted during a four-byte write")

endmodule

// ===== src/scsirf_ctrl.sv =====
// Controller state machine that sequences each access through the datapath.
module scsirf_ctrl import scsirf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_WIDE = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] byte_cnt_ff, byte_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The result register can take a new result when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      byte_cnt_in  = byte_cnt_ff;
      cmd          = '0;
      cmd.byte_sel = byte_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.byte_sel = 2'd0;
            if (out_free) begin
               cmd.execute = 1'b1;
               if (sts.wide_write) begin
                  byte_cnt_in = 2'd1;
                  state_in    = ST_WIDE;
               end else begin
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_WIDE: begin
            cmd.wide_step = 1'b1;
            byte_cnt_in   = byte_cnt_ff + 2'd1;
            if (byte_cnt_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result stays valid until the receiver takes it.
   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         byte_cnt_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_cnt_ff  <= byte_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/scsirf_dp.sv =====
// Datapath: register array, interrupt status registers, access decode and result register.
module scsirf_dp import scsirf_pkg::*; #(
   parameter int REG_FILE_BYTES = REG_FILE_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                req_operation,
   input  logic [OFFSET_W-1:0] req_reg_offset,
   input  logic [SIZE_W-1:0]   req_access_size,
   input  logic [DATA_W-1:0]   req_write_data,
   output logic [BYTE_W-1:0]   rsp_read_data,
   output logic                rsp_status
);

   localparam int AW = $clog2(REG_FILE_BYTES);
   localparam logic [OFFSET_W:0] LIMIT = (OFFSET_W + 1)'(REG_FILE_BYTES);

   // Held item.
   logic                op_ff;
   logic [OFFSET_W-1:0] off_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [DATA_W-1:0]   data_ff;

   // Register array, its valid bits and the registered read port.
   logic [BYTE_W-1:0]         mem_ff [REG_FILE_BYTES];
   logic [REG_FILE_BYTES-1:0] vld_ff;
   logic [BYTE_W-1:0]         mem_q_ff;
   logic                      vld_q_ff;

   // DSTAT, ISTAT, SIST0, SIST1 and STEST4, which have side effects, live in flip-flops.
   logic [BYTE_W-1:0] dstat_ff, dstat_in;
   logic [BYTE_W-1:0] istat_ff, istat_in;
   logic [BYTE_W-1:0] sist0_ff, sist0_in;
   logic [BYTE_W-1:0] sist1_ff, sist1_in;
   logic [BYTE_W-1:0] stest4_ff, stest4_in;

   // Result register.
   logic [BYTE_W-1:0] read_data_ff, read_data_in;
   logic              status_ff, status_in;

   logic [AW-1:0]     idx;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] wr_byte;
   logic [BYTE_W-1:0] mem_byte;
   logic [BYTE_W-1:0] cur_byte;
   logic              in_range, wide_fit, is_read, reject;
   logic              rd_ok, byte_wr, wide_ok, special, mem_we;

   // Decode of the held access.
   always_comb begin
      idx      = off_ff[AW-1:0];
      in_range = {1'b0, off_ff} < LIMIT;
      wide_fit = is_wide_reg(off_ff) && (({1'b0, off_ff} + (OFFSET_W + 1)'(3)) < LIMIT);
      is_read  = (op_ff == OP_READ);
      if (!in_range) begin
         reject = 1'b1;
      end else if (is_read) begin
         reject = (size_ff != SIZE_BYTE);
      end else if (size_ff == SIZE_WORD) begin
         reject = !wide_fit;
      end else begin
         reject = (size_ff != SIZE_BYTE) || (off_ff == OFF_DSTAT);
      end
      rd_ok   = !reject && is_read;
      wide_ok = !reject && !is_read && (size_ff == SIZE_WORD);
      byte_wr = !reject && !is_read && (size_ff == SIZE_BYTE);
      special = (off_ff == OFF_DSTAT) || (off_ff == OFF_ISTAT) || (off_ff == OFF_SIST0) ||
                (off_ff == OFF_SIST1) || (off_ff == OFF_STEST4);
   end

   assign sts.wide_write = wide_ok;

   // Current byte of the addressed register; unwritten entries read their reset value.
   always_comb begin
      mem_byte = vld_q_ff ? mem_q_ff : reg_reset_value(off_ff);
      case (off_ff)
         OFF_DSTAT:  cur_byte = dstat_ff;
         OFF_ISTAT:  cur_byte = istat_ff;
         OFF_SIST0:  cur_byte = sist0_ff;
         OFF_SIST1:  cur_byte = sist1_ff;
         OFF_STEST4: cur_byte = stest4_ff;
         default:    cur_byte = mem_byte;
      endcase
      wr_byte = data_ff[BYTE_W-1:0];
      if (off_ff == OFF_STEST3) begin
         wr_byte = wr_byte & ~STEST3_CSF;
      end
   end

   // Side effects on the flag registers.
   always_comb begin
      dstat_in  = dstat_ff;
      istat_in  = istat_ff;
      sist0_in  = sist0_ff;
      sist1_in  = sist1_ff;
      stest4_in = stest4_ff;
      if (cmd.execute && rd_ok) begin
         // Reads acknowledge pending interrupts.
         if ((off_ff == OFF_DSTAT) && ((cur_byte & DSTAT_SIR) != '0)) begin
            dstat_in = cur_byte & ~DSTAT_SIR;
            istat_in = istat_ff & ~ISTAT_DIP;
         end
         if (off_ff == OFF_CTEST2) begin
            istat_in = istat_ff & ~ISTAT_SIGP;
         end
         if ((off_ff == OFF_SIST0) && ((cur_byte & SIST0_MA) != '0)) begin
            sist0_in = cur_byte & ~SIST0_MA;
            istat_in = istat_ff & ~ISTAT_SIP;
         end
         if ((off_ff == OFF_SIST1) && ((cur_byte & SIST1_STO) != '0)) begin
            sist1_in = cur_byte & ~SIST1_STO;
            istat_in = istat_ff & ~ISTAT_SIP;
         end
      end
      if (cmd.execute && byte_wr) begin
         case (off_ff)
            OFF_ISTAT:  istat_in  = wr_byte;
            OFF_SIST0:  sist0_in  = wr_byte;
            OFF_SIST1:  sist1_in  = wr_byte;
            OFF_STEST4: stest4_in = wr_byte;
            default:    stest4_in = stest4_ff;
         endcase
         // Setting QEN in STEST1 locks STEST4.
         if ((off_ff == OFF_STEST1) && ((wr_byte & STEST1_QEN) != '0)) begin
            stest4_in = stest4_ff | STEST4_LOCK;
         end
      end
   end

   // Array write port: byte writes, or one lane of a four-byte write per cycle.
   always_comb begin
      mem_we  = (cmd.execute && (wide_ok || (byte_wr && !special))) || cmd.wide_step;
      wr_addr = idx + AW'(cmd.byte_sel);
      if (cmd.wide_step || wide_ok) begin
         wr_data = data_ff[{cmd.byte_sel, 3'b000} +: BYTE_W];
      end else begin
         wr_data = wr_byte;
      end
   end

   // Result of the held item.
   always_comb begin
      read_data_in = read_data_ff;
      status_in    = status_ff;
      if (cmd.execute) begin
         read_data_in = rd_ok ? cur_byte : '0;
         status_in    = reject;
      end
   end

   assign rsp_read_data = read_data_ff;
   assign rsp_status    = status_ff;

   // Item capture, array read and write, result register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         off_ff   <= req_reg_offset;
         size_ff  <= req_access_size;
         data_ff  <= req_write_data;
         mem_q_ff <= mem_ff[req_reg_offset[AW-1:0]];
      end
      if (mem_we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      read_data_ff <= read_data_in;
      status_ff    <= status_in;
   end

   // Valid bits and flag registers take their reset values at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         vld_q_ff  <= 1'b0;
         dstat_ff  <= DSTAT_RESET;
         istat_ff  <= '0;
         sist0_ff  <= '0;
         sist1_ff  <= '0;
         stest4_ff <= STEST4_RESET;
      end else begin
         if (mem_we) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (cmd.capture) begin
            vld_q_ff <= vld_ff[req_reg_offset[AW-1:0]];
         end
         dstat_ff  <= dstat_in;
         istat_ff  <= istat_in;
         sist0_ff  <= sist0_in;
         sist1_ff  <= sist1_in;
         stest4_ff <= stest4_in;
      end
   end

endmodule

// ===== tb/scsi_controller_register_file_top_tb.sv =====
// Self-checking testbench for the SCSI controller register file top level.
module scsi_controller_register_file_top_tb import scsirf_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   // Result status codes.
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // Whether a stimulus row carries its own expected result.
   localparam logic ROW_PREDICTED = 1'b0;
   localparam logic ROW_TYPED     = 1'b1;

   // Offsets used by the stimulus beyond those of the package.
   localparam logic [OFFSET_W-1:0] OFF_FIRST      = 12'h000;
   localparam logic [OFFSET_W-1:0] OFF_LAST       = 12'h0FF;
   localparam logic [OFFSET_W-1:0] OFF_WINDOW_END = 12'h100;
   localparam logic [OFFSET_W-1:0] OFF_MAX        = 12'hFFF;
   localparam logic [OFFSET_W-1:0] OFF_DSA        = 12'h010;
   localparam logic [OFFSET_W-1:0] OFF_SCRATCHJ   = 12'h07C;

   // Access sizes that the block always rejects.
   localparam logic [SIZE_W-1:0] SIZE_HALF  = 4'd2;
   localparam logic [SIZE_W-1:0] SIZE_DWORD = 4'd8;

   localparam int DIRECTED_ROWS   = 25;
   localparam int RANDOM_ITEMS    = 825;
   localparam int IDLE_PERCENT    = 9;
   localparam int QUIET_FIRST     = 400;
   localparam int QUIET_LAST      = 550;
   localparam int PRESSURE_AT     = 200;
   localparam int PRESSURE_CYCLES = 64;
   localparam int DRAIN_CYCLES    = 16;
   localparam int CYCLE_LIMIT     = 200000;

   typedef struct packed {
      logic                operation;
      logic [OFFSET_W-1:0] reg_offset;
      logic [SIZE_W-1:0]   access_size;
      logic [DATA_W-1:0]   write_data;
      logic                typed_in;
      logic [BYTE_W-1:0]   read_data;
      logic                status;
   } stim_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              status;
   } access_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   scsirf_req_if req_chan ();
   scsirf_rsp_if rsp_chan ();

   scsi_controller_register_file_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   stim_row_type        directed_rows [DIRECTED_ROWS];
   stim_row_type        bus_accesses [$];
   stim_row_type        offered_access;
   access_result_type   pending_results [$];
   logic [BYTE_W-1:0]   shadow_regs [0:255];
   logic [OFFSET_W-1:0] word_reg_starts [13];
   int unsigned         accepted_items = 0;
   int unsigned         results_seen = 0;
   int unsigned         hold_cycles = 0;
   int unsigned         cycle_count = 0;
   int unsigned         mismatches = 0;
   logic                pressure_done = 1'b0;

   // Carry out one bus access on the shadow registers and return its result.
   function automatic access_result_type register_window_access(input stim_row_type a);
      access_result_type r;
      logic [BYTE_W-1:0] old_byte;
      logic [BYTE_W-1:0] new_byte;
      logic [7:0]        idx;
      logic              word_hit;
      r.read_data = '0;
      r.status    = STATUS_OK;
      idx         = a.reg_offset[7:0];
      word_hit    = 1'b0;
      foreach (word_reg_starts[i]) begin
         if (word_reg_starts[i] == a.reg_offset) begin
            word_hit = 1'b1;
         end
      end
      if (a.reg_offset >= OFF_WINDOW_END) begin
         r.status = STATUS_REJECT;
      end else if (a.operation == OP_READ) begin
         if (a.access_size != SIZE_BYTE) begin
            r.status = STATUS_REJECT;
         end else begin
            // The old value is returned; acknowledged flags clear afterwards.
            old_byte    = shadow_regs[idx];
            r.read_data = old_byte;
            if (a.reg_offset == OFF_DSTAT && (old_byte & DSTAT_SIR) != 0) begin
               shadow_regs[OFF_DSTAT[7:0]] = old_byte & ~DSTAT_SIR;
               shadow_regs[OFF_ISTAT[7:0]] = shadow_regs[OFF_ISTAT[7:0]] & ~ISTAT_DIP;
            end
            if (a.reg_offset == OFF_CTEST2) begin
               shadow_regs[OFF_ISTAT[7:0]] = shadow_regs[OFF_ISTAT[7:0]] & ~ISTAT_SIGP;
            end
            if (a.reg_offset == OFF_SIST0 && (old_byte & SIST0_MA) != 0) begin
               shadow_regs[OFF_SIST0[7:0]] = old_byte & ~SIST0_MA;
               shadow_regs[OFF_ISTAT[7:0]] = shadow_regs[OFF_ISTAT[7:0]] & ~ISTAT_SIP;
            end
            if (a.reg_offset == OFF_SIST1 && (old_byte & SIST1_STO) != 0) begin
               shadow_regs[OFF_SIST1[7:0]] = old_byte & ~SIST1_STO;
               shadow_regs[OFF_ISTAT[7:0]] = shadow_regs[OFF_ISTAT[7:0]] & ~ISTAT_SIP;
            end
         end
      end else if (a.access_size == SIZE_WORD) begin
         // Four-byte writes land low byte first on a 32-bit register.
         if (word_hit) begin
            shadow_regs[idx]        = a.write_data[7:0];
            shadow_regs[idx + 8'd1] = a.write_data[15:8];
            shadow_regs[idx + 8'd2] = a.write_data[23:16];
            shadow_regs[idx + 8'd3] = a.write_data[31:24];
         end else begin
            r.status = STATUS_REJECT;
         end
      end else if (a.access_size != SIZE_BYTE || a.reg_offset == OFF_DSTAT) begin
         r.status = STATUS_REJECT;
      end else begin
         new_byte = a.write_data[7:0];
         if (a.reg_offset == OFF_STEST3) begin
            new_byte = new_byte & ~STEST3_CSF;
         end
         shadow_regs[idx] = new_byte;
         if (a.reg_offset == OFF_STEST1 && (new_byte & STEST1_QEN) != 0) begin
            shadow_regs[OFF_STEST4[7:0]] = shadow_regs[OFF_STEST4[7:0]] | STEST4_LOCK;
         end
      end
      return r;
   endfunction

   // Append one predicted access to the stimulus.
   task automatic queue_access(input logic op, input logic [OFFSET_W-1:0] off,
                               input logic [SIZE_W-1:0] size, input logic [DATA_W-1:0] data);
      stim_row_type row;
      row             = '0;
      row.operation   = op;
      row.reg_offset  = off;
      row.access_size = size;
      row.write_data  = data;
      row.typed_in    = ROW_PREDICTED;
      bus_accesses.push_back(row);
   endtask

   // Sender: predict each accepted item and offer the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.operation   <= OP_READ;
         req_chan.reg_offset  <= '0;
         req_chan.access_size <= SIZE_BYTE;
         req_chan.write_data  <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            access_result_type predicted;
            access_result_type typed;
            predicted = register_window_access(offered_access);
            typed.read_data = offered_access.read_data;
            typed.status    = offered_access.status;
            pending_results.push_back(offered_access.typed_in ? typed : predicted);
            accepted_items++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (bus_accesses.size() != 0 &&
                ((accepted_items >= QUIET_FIRST && accepted_items < QUIET_LAST) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               offered_access          = bus_accesses.pop_front();
               req_chan.valid          <= 1'b1;
               req_chan.operation      <= offered_access.operation;
               req_chan.reg_offset     <= offered_access.reg_offset;
               req_chan.access_size    <= offered_access.access_size;
               req_chan.write_data     <= offered_access.write_data;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each result item against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            access_result_type want;
            if (pending_results.size() == 0) begin
               $error("result with no expectation: read_data %0h status %0b",
                      rsp_chan.read_data, rsp_chan.status);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_chan.read_data !== want.read_data) begin
                  $error("read_data: expected %0h, actual %0h",
                         want.read_data, rsp_chan.read_data);
                  mismatches++;
               end
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0b, actual %0b", want.status, rsp_chan.status);
                  mismatches++;
               end
            end
            results_seen++;
         end
         // One long hold-off lets the block fill up and stall its input.
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold_cycles   = PRESSURE_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("scsi_controller_register_file_top_tb NOT OK");
         $finish;
      end
   end

   initial begin
      int unsigned       pick;
      int unsigned       k;
      logic [OFFSET_W-1:0] off;

      word_reg_starts = '{12'h010, 12'h01C, 12'h02C, 12'h034, 12'h05C, 12'h060, 12'h064,
                          12'h068, 12'h06C, 12'h070, 12'h074, 12'h078, 12'h07C};

      // Shadow registers start from the reset contents.
      foreach (shadow_regs[i]) begin
         shadow_regs[i] = '0;
      end
      shadow_regs[OFF_DSTAT[7:0]]  = DSTAT_RESET;
      shadow_regs[OFF_CTEST3[7:0]] = CTEST3_RESET;
      shadow_regs[OFF_STEST4[7:0]] = STEST4_RESET;

      // Directed rows: reset values, window edges, rejects and side effects.
      directed_rows = '{
         '{OP_READ,  OFF_DSTAT,      SIZE_BYTE,  32'h0, ROW_TYPED, DSTAT_RESET, STATUS_OK},
         '{OP_READ,  OFF_CTEST3,     SIZE_BYTE,  32'h0, ROW_TYPED, CTEST3_RESET, STATUS_OK},
         '{OP_READ,  OFF_STEST4,     SIZE_BYTE,  32'h0, ROW_TYPED, STEST4_RESET, STATUS_OK},
         '{OP_READ,  OFF_FIRST,      SIZE_BYTE,  32'h0, ROW_TYPED, 8'h00, STATUS_OK},
         '{OP_READ,  OFF_WINDOW_END, SIZE_BYTE,  32'h0, ROW_TYPED, 8'h00, STATUS_REJECT},
         '{OP_READ,  OFF_MAX,        SIZE_BYTE,  32'h0, ROW_TYPED, 8'h00, STATUS_REJECT},
         '{OP_WRITE, OFF_MAX,        SIZE_WORD,  32'hFFFF_FFFF, ROW_TYPED, 8'h00, STATUS_REJECT},
         '{OP_READ,  OFF_FIRST,      SIZE_DWORD, 32'h0, ROW_TYPED, 8'h00, STATUS_REJECT},
         '{OP_WRITE, OFF_DSTAT,      SIZE_BYTE,  32'hFFFF_FFFF, ROW_TYPED, 8'h00, STATUS_REJECT},
         '{OP_WRITE, OFF_DSA,        SIZE_WORD,  32'hFFFF_FFFF, ROW_TYPED, 8'h00, STATUS_OK},
         '{OP_WRITE, OFF_SCRATCHJ,   SIZE_WORD,  32'h1234_5678, ROW_TYPED, 8'h00, STATUS_OK},
         '{OP_READ,  OFF_SCRATCHJ + 12'd3, SIZE_BYTE, 32'h0, ROW_PREDICTED, 8'h00, STATUS_OK},
         '{OP_WRITE, OFF_DSA + 12'd1, SIZE_WORD, 32'hA5A5_A5A5, ROW_TYPED, 8'h00, STATUS_REJECT},
         '{OP_WRITE, OFF_LAST,       SIZE_HALF,  32'h0000_00FF, ROW_TYPED, 8'h00, STATUS_REJECT},
         '{OP_WRITE, OFF_ISTAT,      SIZE_BYTE,  32'hFFFF_FFFF, ROW_TYPED, 8'h00, STATUS_OK},
         '{OP_WRITE, OFF_SIST0,      SIZE_BYTE,  32'h0000_00FF, ROW_TYPED, 8'h00, STATUS_OK},
         '{OP_WRITE, OFF_SIST1,      SIZE_BYTE,  32'h0000_00FF, ROW_TYPED, 8'h00, STATUS_OK},
         '{OP_READ,  OFF_SIST0,      SIZE_BYTE,  32'h0, ROW_PREDICTED, 8'h00, STATUS_OK},
         '{OP_READ,  OFF_SIST1,      SIZE_BYTE,  32'h0, ROW_PREDICTED, 8'h00, STATUS_OK},
         '{OP_READ,  OFF_CTEST2,     SIZE_BYTE,  32'h0, ROW_PREDICTED, 8'h00, STATUS_OK},
         '{OP_READ,  OFF_ISTAT,      SIZE_BYTE,  32'h0, ROW_PREDICTED, 8'h00, STATUS_OK},
         '{OP_WRITE, OFF_STEST3,     SIZE_BYTE,  32'h0000_00FF, ROW_TYPED, 8'h00, STATUS_OK},
         '{OP_READ,  OFF_STEST3,     SIZE_BYTE,  32'h0, ROW_PREDICTED, 8'h00, STATUS_OK},
         '{OP_WRITE, OFF_STEST1,     SIZE_BYTE,  32'h0000_0008, ROW_TYPED, 8'h00, STATUS_OK},
         '{OP_READ,  OFF_STEST4,     SIZE_BYTE,  32'h0, ROW_PREDICTED, 8'h00, STATUS_OK}
      };
      foreach (directed_rows[i]) begin
         bus_accesses.push_back(directed_rows[i]);
      end

      // Random part: flag, test-register, word and byte sequences, some noise.
      while (bus_accesses.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            // Raise interrupt flags, then acknowledge them by reading.
            queue_access(OP_WRITE, OFF_ISTAT, SIZE_BYTE, $urandom);
            queue_access(OP_WRITE, OFF_SIST0, SIZE_BYTE, $urandom);
            queue_access(OP_WRITE, OFF_SIST1, SIZE_BYTE, $urandom);
            queue_access(OP_READ, $urandom_range(0, 1) ? OFF_SIST1 : OFF_SIST0,
                         SIZE_BYTE, $urandom);
            queue_access(OP_READ, OFF_ISTAT, SIZE_BYTE, $urandom);
            queue_access(OP_READ, OFF_CTEST2, SIZE_BYTE, $urandom);
            queue_access(OP_READ, OFF_ISTAT, SIZE_BYTE, $urandom);
            queue_access(OP_READ, OFF_SIST0, SIZE_BYTE, $urandom);
            queue_access(OP_READ, OFF_SIST1, SIZE_BYTE, $urandom);
            queue_access(OP_READ, OFF_DSTAT, SIZE_BYTE, $urandom);
         end else if (pick < 35) begin
            // Test registers: lock bit, self-clearing bit, occasional unlock.
            if ($urandom_range(0, 2) == 0) begin
               queue_access(OP_WRITE, OFF_STEST4, SIZE_BYTE, $urandom);
            end
            queue_access(OP_WRITE, OFF_STEST1, SIZE_BYTE, $urandom);
            queue_access(OP_WRITE, OFF_STEST3, SIZE_BYTE, $urandom);
            queue_access(OP_READ, OFF_STEST1, SIZE_BYTE, $urandom);
            queue_access(OP_READ, OFF_STEST3, SIZE_BYTE, $urandom);
            queue_access(OP_READ, OFF_STEST4, SIZE_BYTE, $urandom);
         end else if (pick < 60) begin
            // Word write to a 32-bit register, then its bytes read back.
            off = word_reg_starts[$urandom_range(0, 12)];
            queue_access(OP_WRITE, off, SIZE_WORD, $urandom);
            if ($urandom_range(0, 3) == 0) begin
               queue_access(OP_WRITE, off + 12'($urandom_range(0, 3)), SIZE_BYTE, $urandom);
            end
            for (k = 0; k < 4; k++) begin
               queue_access(OP_READ, off + 12'(k), SIZE_BYTE, $urandom);
            end
         end else if (pick < 80) begin
            // Byte write anywhere in the window, then read it back.
            off = 12'($urandom_range(0, 255));
            queue_access(OP_WRITE, off, SIZE_BYTE, $urandom);
            queue_access(OP_READ, off, SIZE_BYTE, $urandom);
         end else begin
            // Noise: any field value, partly outside the window.
            if ($urandom_range(0, 4) == 0) begin
               off = 12'($urandom_range(0, 4095));
            end else begin
               off = 12'($urandom_range(0, 255));
            end
            queue_access(1'($urandom_range(0, 1)), off, 4'($urandom_range(1, 8)), $urandom);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every item to go out and every result to come back.
      while (bus_accesses.size() != 0 || req_chan.valid || pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("scsi_controller_register_file_top_tb OK");
      end else begin
         $display("scsi_controller_register_file_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/scsirf_pkg.sv
src/scsirf_req_if.sv
src/scsirf_rsp_if.sv
src/scsirf_ctrl.sv
src/scsirf_dp.sv
src/scsi_controller_register_file_top.sv
tb/scsi_controller_register_file_top_tb.sv
